// File: hw/rtl/cbf_pkg.sv
package cbf_pkg;

    localparam int COORD_W      = 32;
    localparam int SPC_W        = 7;
    localparam int IDX_W        = 6;
    localparam int T_FRAC_BITS  = 16;
    localparam int T_W          = T_FRAC_BITS + 1;
    localparam int MAX_SAMPLES  = 64;
    localparam int SPC_RESET    = 10;
    localparam int PROD_W       = COORD_W + 1 + T_W + 1;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord ctrl1_x;
        t_coord ctrl1_y;
        t_coord ctrl2_x;
        t_coord ctrl2_y;
        t_coord end_x;
        t_coord end_y;
    } t_curve;

    typedef struct packed {
        t_coord             point_x;
        t_coord             point_y;
        logic [IDX_W-1:0]   sample_number;
        logic               last_point;
    } t_point;

endpackage

// File: hw/rtl/cbf_curve_if.sv
interface cbf_curve_if;
    import cbf_pkg::*;

    logic   valid;
    logic   ready;
    t_curve payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/cbf_point_if.sv
interface cbf_point_if;
    import cbf_pkg::*;

    logic   valid;
    logic   ready;
    t_point payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/cubic_bezier_flattener_unit.sv
// cubic bezier flattener
// i_curve (valid/ready) carries one curve per transaction: start, two control
// points and end, signed Q16.16. o_point (valid/ready) returns N points per
// curve at t = (i+1)/N, sample i = 0 .. N-1, with last_point set on the final
// one, which equals the end point. N is written through i_cfg_we/i_cfg_wdata;
// the user is to write it only while the block is idle, and the block itself
// does not enforce this. 0 is taken as 1 and values above 64 as 64. One
// shared lerp unit (33x18 multiply, then add) does all twelve interpolations
// of a sample. Per curve: the block takes the transaction, the restoring
// division 65536/N gives the t step, then each point runs a t update, the
// lerps and the output load. i_curve.ready is high only while no curve is in
// work. The result sits in an output register, so the next point is computed
// while the previous waits; a stall on o_point holds the sequencer at the
// output load until the register frees.
// Reset (synchronous, active low) sets N to 10, returns the sequencer to
// idle and drops o_point.valid.
module cubic_bezier_flattener_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    cbf_curve_if.sink                i_curve,
    cbf_point_if.source              o_point,
    input  logic                     i_cfg_we,
    input  logic [cbf_pkg::SPC_W-1:0] i_cfg_wdata
);
    import cbf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_TSTEP = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam logic [2:0] L_A01  = 3'd0;
    localparam logic [2:0] L_A12  = 3'd1;
    localparam logic [2:0] L_A23  = 3'd2;
    localparam logic [2:0] L_B012 = 3'd3;
    localparam logic [2:0] L_B123 = 3'd4;
    localparam logic [2:0] L_C    = 3'd5;

    localparam logic [4:0] DIV_TOP = 5'(T_FRAC_BITS);

    logic [2:0]             r_state, n_state;
    logic [SPC_W-1:0]       r_spc;
    logic [SPC_W-1:0]       r_n, n_n;
    t_curve                 r_curve;
    logic [4:0]             r_cnt, n_cnt;
    logic [SPC_W-1:0]       r_drem, n_drem;
    logic [T_W-1:0]         r_q, n_q;
    logic [SPC_W-1:0]       r_acc, n_acc;
    logic [T_W-1:0]         r_t, n_t;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [2:0]             r_step, n_step;
    logic                   r_coord, n_coord;
    t_coord                 r_w0, r_w1, r_w2, n_w0, n_w1, n_w2;
    t_coord                 r_res_x, n_res_x;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic                   r_out_valid, n_out_valid;
    t_point                 r_out, n_out;
    // result payload waits in a holding copy during emit
    t_point                 r_hold;

    t_coord                 v0, v1, v2, v3, op_a, op_b, lerp_res;
    logic signed [COORD_W:0] diff;
    logic [SPC_W:0]         rem_sh, acc_sum;
    logic                   div_ge, acc_carry, is_last;
    logic [SPC_W-1:0]       n_clamped;

    assign i_curve.ready   = (r_state == S_IDLE);
    assign o_point.valid   = r_out_valid;
    assign o_point.payload = r_out;

    always_comb begin
        priority if (r_spc == '0) begin
            n_clamped = SPC_W'(1);
        end else if (r_spc > SPC_W'(MAX_SAMPLES)) begin
            n_clamped = SPC_W'(MAX_SAMPLES);
        end else begin
            n_clamped = r_spc;
        end
    end

    always_comb begin
        v0 = r_coord ? r_curve.start_y : r_curve.start_x;
        v1 = r_coord ? r_curve.ctrl1_y : r_curve.ctrl1_x;
        v2 = r_coord ? r_curve.ctrl2_y : r_curve.ctrl2_x;
        v3 = r_coord ? r_curve.end_y   : r_curve.end_x;
        unique case (r_step)
            L_A01:   begin op_a = v0;   op_b = v1;   end
            L_A12:   begin op_a = v1;   op_b = v2;   end
            L_A23:   begin op_a = v2;   op_b = v3;   end
            L_B012:  begin op_a = r_w0; op_b = r_w1; end
            L_B123:  begin op_a = r_w1; op_b = r_w2; end
            default: begin op_a = r_w0; op_b = r_w1; end
        endcase
    end

    // shared lerp unit: multiply, register, then floor-shift and add
    assign diff     = $signed({op_b[COORD_W-1], op_b}) - $signed({op_a[COORD_W-1], op_a});
    assign lerp_res = op_a + COORD_W'(r_prod >>> T_FRAC_BITS);

    // restoring division 65536 / n, one quotient bit per cycle
    assign rem_sh = {r_drem, (r_cnt == DIV_TOP)};
    assign div_ge = rem_sh >= {1'b0, r_n};

    assign acc_sum   = {1'b0, r_acc} + {1'b0, r_drem};
    assign acc_carry = acc_sum >= {1'b0, r_n};
    assign is_last   = ({1'b0, r_idx} + SPC_W'(1)) == r_n;

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_cnt       = r_cnt;
        n_drem      = r_drem;
        n_q         = r_q;
        n_acc       = r_acc;
        n_t         = r_t;
        n_idx       = r_idx;
        n_step      = r_step;
        n_coord     = r_coord;
        n_w0        = r_w0;
        n_w1        = r_w1;
        n_w2        = r_w2;
        n_res_x     = r_res_x;
        n_prod      = r_prod;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && o_point.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_curve.valid) begin
                    n_n     = n_clamped;
                    n_cnt   = DIV_TOP;
                    n_drem  = '0;
                    n_q     = '0;
                    n_acc   = '0;
                    n_t     = '0;
                    n_idx   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_drem = div_ge ? SPC_W'(rem_sh - {1'b0, r_n}) : SPC_W'(rem_sh);
                n_q    = {r_q[T_W-2:0], div_ge};
                n_cnt  = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = S_TSTEP;
                end
            end
            S_TSTEP: begin
                n_t     = r_t + r_q + T_W'(acc_carry);
                n_acc   = acc_carry ? SPC_W'(acc_sum - {1'b0, r_n}) : SPC_W'(acc_sum);
                n_step  = L_A01;
                n_coord = 1'b0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = diff * $signed({1'b0, r_t});
                n_state = S_ADD;
            end
            S_ADD: begin
                n_state = S_MUL;
                n_step  = r_step + 3'd1;
                unique case (r_step)
                    L_A01, L_B012: n_w0 = lerp_res;
                    L_A12, L_B123: n_w1 = lerp_res;
                    L_A23:         n_w2 = lerp_res;
                    default: begin
                        n_step = L_A01;
                        if (!r_coord) begin
                            n_res_x = lerp_res;
                            n_coord = 1'b1;
                        end else begin
                            n_out.point_x       = r_res_x;
                            n_out.point_y       = lerp_res;
                            n_out.sample_number = r_idx;
                            n_out.last_point    = is_last;
                            n_state             = S_EMIT;
                        end
                    end
                endcase
            end
            S_EMIT: begin
                if (!r_out_valid || o_point.ready) begin
                    n_out_valid = 1'b1;
                    n_idx       = r_idx + IDX_W'(1);
                    n_state     = r_hold.last_point ? S_IDLE : S_TSTEP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_spc       <= SPC_W'(SPC_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_spc <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_curve.valid) begin
            r_curve <= i_curve.payload;
        end
        r_n     <= n_n;
        r_cnt   <= n_cnt;
        r_drem  <= n_drem;
        r_q     <= n_q;
        r_acc   <= n_acc;
        r_t     <= n_t;
        r_idx   <= n_idx;
        r_step  <= n_step;
        r_coord <= n_coord;
        r_w0    <= n_w0;
        r_w1    <= n_w1;
        r_w2    <= n_w2;
        r_res_x <= n_res_x;
        r_prod  <= n_prod;
        if (r_state == S_ADD) begin
            r_hold <= n_out;
        end
        if (r_state == S_EMIT && (!r_out_valid || o_point.ready)) begin
            r_out <= r_hold;
        end
    end

endmodule
